// ===== rtl/lds_pkg.sv =====
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and constants of the LOOK disk scheduler: field widths,
// configuration register indexes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lds_pkg;

    // field widths
    localparam int TRACK_W    = 12;
    localparam int TOTAL_W    = 13;
    localparam int CFG_AW     = 1;
    localparam int CFG_DW     = 12;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 56;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_START_POS  = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_DIR_LEFT   = 1'd1;

    // ram read address source
    typedef enum logic [1:0] {
        ADDR_INS,
        ADDR_SRCH,
        ADDR_SRV
    } t_addr_sel;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_RUN_INIT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SRV_INIT,
        ST_SRV_RD,
        ST_SRV_LOAD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic      ld_in;
        logic      ins_start;
        logic      ins_shift;
        logic      ins_put;
        logic      srch_init;
        logic      srch_step;
        logic      srv_init;
        logic      srv_emit;
        logic      clr_count;
        t_addr_sel addr_sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic pos_one;
        logic rd_gt_track;
        logic last_req;
        logic rd_lt_head;
        logic j_last;
        logic srv_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/lds_ram.sv =====
// ----------------------------------------------------------------------------
// lds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/lds_ctrl.sv =====
// ----------------------------------------------------------------------------
// lds_ctrl
// Controller of the LOOK disk scheduler: sequences sorted insertion, the
// split search and the service walk, issuing commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire lds_pkg::t_status i_status,
    output lds_pkg::t_cmd         o_cmd
);

    lds_pkg::t_state r_state;
    lds_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lds_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lds_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = lds_pkg::ST_INS_CHK;
            end
            lds_pkg::ST_INS_CHK: begin
                if (i_status.full) begin
                    n_state = i_status.last_req ? lds_pkg::ST_RUN_INIT : lds_pkg::ST_IDLE;
                end else if (i_status.cnt_zero) begin
                    n_state = lds_pkg::ST_INS_PUT;
                end else begin
                    n_state = lds_pkg::ST_INS_RD;
                end
            end
            lds_pkg::ST_INS_RD: begin
                n_state = lds_pkg::ST_INS_CMP;
            end
            lds_pkg::ST_INS_CMP: begin
                if (i_status.rd_gt_track && !i_status.pos_one) begin
                    n_state = lds_pkg::ST_INS_RD;
                end else begin
                    n_state = lds_pkg::ST_INS_PUT;
                end
            end
            lds_pkg::ST_INS_PUT: begin
                n_state = i_status.last_req ? lds_pkg::ST_RUN_INIT : lds_pkg::ST_IDLE;
            end
            lds_pkg::ST_RUN_INIT: begin
                n_state = lds_pkg::ST_SRCH_RD;
            end
            lds_pkg::ST_SRCH_RD: begin
                n_state = lds_pkg::ST_SRCH_CMP;
            end
            lds_pkg::ST_SRCH_CMP: begin
                if (i_status.rd_lt_head && !i_status.j_last) begin
                    n_state = lds_pkg::ST_SRCH_RD;
                end else begin
                    n_state = lds_pkg::ST_SRV_INIT;
                end
            end
            lds_pkg::ST_SRV_INIT: begin
                n_state = lds_pkg::ST_SRV_RD;
            end
            lds_pkg::ST_SRV_RD: begin
                n_state = lds_pkg::ST_SRV_LOAD;
            end
            lds_pkg::ST_SRV_LOAD: begin
                if (i_status.out_free) begin
                    n_state = i_status.srv_last ? lds_pkg::ST_IDLE : lds_pkg::ST_SRV_RD;
                end
            end
            default: begin
                n_state = lds_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.addr_sel = lds_pkg::ADDR_INS;
        o_in_ready = 1'b0;
        case (r_state)
            lds_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.ld_in     = i_in_valid;
                o_cmd.ins_start = i_in_valid;
            end
            lds_pkg::ST_INS_CMP: begin
                o_cmd.ins_shift = i_status.rd_gt_track;
            end
            lds_pkg::ST_INS_PUT: begin
                o_cmd.ins_put = 1'b1;
            end
            lds_pkg::ST_RUN_INIT: begin
                o_cmd.srch_init = 1'b1;
            end
            lds_pkg::ST_SRCH_RD: begin
                o_cmd.addr_sel = lds_pkg::ADDR_SRCH;
            end
            lds_pkg::ST_SRCH_CMP: begin
                o_cmd.addr_sel  = lds_pkg::ADDR_SRCH;
                o_cmd.srch_step = i_status.rd_lt_head;
            end
            lds_pkg::ST_SRV_INIT: begin
                o_cmd.srv_init = 1'b1;
            end
            lds_pkg::ST_SRV_RD: begin
                o_cmd.addr_sel = lds_pkg::ADDR_SRV;
            end
            lds_pkg::ST_SRV_LOAD: begin
                o_cmd.addr_sel  = lds_pkg::ADDR_SRV;
                o_cmd.srv_emit  = i_status.out_free;
                o_cmd.clr_count = i_status.out_free && i_status.srv_last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // a run only starts from the insertion or drop decision
    a_run_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lds_pkg::ST_RUN_INIT) |->
        ($past(r_state) == lds_pkg::ST_INS_PUT || $past(r_state) == lds_pkg::ST_INS_CHK))
        else $error("run started outside insertion");

    // a load without room in the output register never leaves the load state
    a_load_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lds_pkg::ST_SRV_LOAD && !i_status.out_free) |=>
        (r_state == lds_pkg::ST_SRV_LOAD))
        else $error("result lost while output stalled");

endmodule

`default_nettype wire

// ===== rtl/lds_datapath.sv =====
// ----------------------------------------------------------------------------
// lds_datapath
// Datapath of the LOOK disk scheduler: configuration registers, request
// store, insertion pointer, split index, service cursor, seek arithmetic
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_datapath #(
    parameter int MAX_REQUESTS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lds_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [lds_pkg::CFG_DW-1:0]     i_cfg_wdata,
    input  wire logic [lds_pkg::TRACK_W-1:0]    i_track,
    input  wire logic                           i_last,
    input  wire lds_pkg::t_cmd                  i_cmd,
    output lds_pkg::t_status                    o_status,
    output logic                                o_m_valid,
    input  wire logic                           i_m_ready,
    output logic [lds_pkg::TRACK_W-1:0]         o_from,
    output logic [lds_pkg::TRACK_W-1:0]         o_to,
    output logic [lds_pkg::TRACK_W-1:0]         o_dist,
    output logic [lds_pkg::TOTAL_W-1:0]         o_total,
    output logic                                o_m_last
);

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int TW    = lds_pkg::TRACK_W;
    localparam int TOT_W = lds_pkg::TOTAL_W;

    // configuration
    logic [TW-1:0]    r_start_pos;
    logic             r_dir_left;

    // run state
    logic [TW-1:0]    r_track;
    logic             r_last;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_pos;
    logic [CNT_W-1:0] r_j;
    logic [IDX_W-1:0] r_cur;
    logic             r_down;
    logic [CNT_W-1:0] r_k;
    logic [TW-1:0]    r_head;
    logic [lds_pkg::TOTAL_W-1:0] r_total;

    // output register
    logic             r_m_valid;
    logic [TW-1:0]    r_from;
    logic [TW-1:0]    r_to;
    logic [TW-1:0]    r_dist;
    logic [lds_pkg::TOTAL_W-1:0] r_out_total;
    logic             r_m_last;

    // ram
    logic [IDX_W-1:0] raddr;
    logic [TW-1:0]    rdata;
    logic             ram_we;
    logic [TW-1:0]    ram_wdata;

    // seek arithmetic
    logic [TW-1:0]    seek_dist;
    logic [lds_pkg::TOTAL_W-1:0] total_next;
    logic [CNT_W-1:0] count_m1;
    logic             out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos <= '0;
            r_dir_left  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lds_pkg::CFG_START_POS: r_start_pos <= i_cfg_wdata[TW-1:0];
                lds_pkg::CFG_DIR_LEFT:  r_dir_left  <= i_cfg_wdata[0];
                default:                r_dir_left  <= r_dir_left;
            endcase
        end
    end

    // read address select
    always_comb begin
        case (i_cmd.addr_sel)
            lds_pkg::ADDR_INS:  raddr = r_pos - IDX_W'(1);
            lds_pkg::ADDR_SRCH: raddr = r_j[IDX_W-1:0];
            lds_pkg::ADDR_SRV:  raddr = r_cur;
            default:            raddr = r_cur;
        endcase
    end

    assign ram_we    = i_cmd.ins_shift | i_cmd.ins_put;
    assign ram_wdata = i_cmd.ins_shift ? rdata : r_track;

    lds_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_REQUESTS),
        .AW    (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (ram_wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // seek distance and running total
    assign seek_dist  = (rdata >= r_head) ? (rdata - r_head) : (r_head - rdata);
    assign total_next = r_total + TOT_W'(seek_dist);
    assign count_m1   = r_count - CNT_W'(1);
    assign out_free   = !r_m_valid || i_m_ready;

    // input latch and insertion pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_track <= i_track;
            r_last  <= i_last;
        end
        if (i_cmd.ins_start) begin
            r_pos <= r_count[IDX_W-1:0];
        end else if (i_cmd.ins_shift) begin
            r_pos <= r_pos - IDX_W'(1);
        end
    end

    // request count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clr_count) begin
            r_count <= '0;
        end else if (i_cmd.ins_put) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // split search and service walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_j     <= '0;
            r_k     <= '0;
            r_head  <= r_start_pos;
            r_total <= '0;
        end else if (i_cmd.srch_step) begin
            r_j <= r_j + CNT_W'(1);
        end
        if (i_cmd.srv_init) begin
            // lower side first when asked for and present, or when nothing is above
            if (r_dir_left ? (r_j != '0) : (r_j == r_count)) begin
                r_down <= 1'b1;
                r_cur  <= IDX_W'(r_j - CNT_W'(1));
            end else begin
                r_down <= 1'b0;
                r_cur  <= r_j[IDX_W-1:0];
            end
        end else if (i_cmd.srv_emit) begin
            r_k     <= r_k + CNT_W'(1);
            r_head  <= rdata;
            r_total <= total_next;
            if (r_down) begin
                if (r_cur == '0) begin
                    r_down <= 1'b0;
                    r_cur  <= r_j[IDX_W-1:0];
                end else begin
                    r_cur <= r_cur - IDX_W'(1);
                end
            end else begin
                if (CNT_W'(r_cur) == count_m1) begin
                    r_down <= 1'b1;
                    r_cur  <= IDX_W'(r_j - CNT_W'(1));
                end else begin
                    r_cur <= r_cur + IDX_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.srv_emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srv_emit) begin
            r_from      <= r_head;
            r_to        <= rdata;
            r_dist      <= seek_dist;
            r_out_total <= total_next;
            r_m_last    <= (r_k == count_m1);
        end
    end

    // status to the controller
    always_comb begin
        o_status.full        = (r_count == CNT_W'(MAX_REQUESTS));
        o_status.cnt_zero    = (r_count == '0);
        o_status.pos_one     = (r_pos == IDX_W'(1));
        o_status.rd_gt_track = (rdata > r_track);
        o_status.last_req    = r_last;
        o_status.rd_lt_head  = (rdata < r_head);
        o_status.j_last      = (r_j == count_m1);
        o_status.srv_last    = (r_k == count_m1);
        o_status.out_free    = out_free;
    end

    assign o_m_valid = r_m_valid;
    assign o_from    = r_from;
    assign o_to      = r_to;
    assign o_dist    = r_dist;
    assign o_total   = r_out_total;
    assign o_m_last  = r_m_last;

    // store never overfills
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REQUESTS))
        else $error("request count above capacity");

    // a result is loaded only when the output register has room
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.srv_emit |-> out_free)
        else $error("result overwrote a pending transaction");

    // service cursor stays inside the stored requests
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.srv_emit |-> (CNT_W'(r_cur) < r_count))
        else $error("service cursor out of range");

    // the final result of a run empties the store
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.srv_emit && r_k == count_m1) |=> (r_count == '0 && r_m_last))
        else $error("store not emptied after final seek");

endmodule

`default_nettype wire

// ===== rtl/look_disk_scheduler.sv =====
// ----------------------------------------------------------------------------
// look_disk_scheduler
// Collects track requests in ascending order and, on the request marked
// last, serves them in LOOK order from the configured head position.
// Insertion: compares stored entries from the top down (those above the new
//   track and the first one not above).
// Run: the split search reads the entries below the head and the first at or
//   above it, then one result is produced per stored request, stalling while
//   the sink holds back; input is held meanwhile.
// Reset clears the count (store empty), configuration and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module look_disk_scheduler #(
    parameter int MAX_REQUESTS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [lds_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  wire logic [lds_pkg::CFG_DW-1:0]        i_cfg_wdata,
    // request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lds_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] request_track
    input  wire logic                              s_tlast,
    // seek stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [11:0] from_track, [23:12] to_track, [35:24] seek_distance,
    // [48:36] total_movement
    output logic [lds_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                   m_tlast
);

    localparam int TW = lds_pkg::TRACK_W;
    localparam int PAD_W = lds_pkg::M_TDATA_W - 3 * TW - lds_pkg::TOTAL_W;

    lds_pkg::t_cmd    cmd;
    lds_pkg::t_status status;

    logic [TW-1:0]               from_track;
    logic [TW-1:0]               to_track;
    logic [TW-1:0]               seek_distance;
    logic [lds_pkg::TOTAL_W-1:0] total_movement;

    lds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lds_datapath #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_track     (s_tdata[TW-1:0]),
        .i_last      (s_tlast),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_m_valid   (m_tvalid),
        .i_m_ready   (m_tready),
        .o_from      (from_track),
        .o_to        (to_track),
        .o_dist      (seek_distance),
        .o_total     (total_movement),
        .o_m_last    (m_tlast)
    );

    // pack result fields, lowest first
    assign m_tdata = {{PAD_W{1'b0}}, total_movement, seek_distance, to_track, from_track};

endmodule

`default_nettype wire

// ===== verif/lds_seek_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_seek_checker
// Watches the configuration port and both streams of the LOOK disk
// scheduler. Keeps its own sorted copy of the pending tracks and, when a
// batch closes, works out the full seek sequence. Each seek leaving the
// block is then compared field by field against the oldest one due.
// ----------------------------------------------------------------------------

module lds_seek_checker #(
    parameter int MAX_REQUESTS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lds_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  wire logic [lds_pkg::CFG_DW-1:0]        i_cfg_wdata,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [lds_pkg::S_TDATA_W-1:0]     s_tdata,   // [11:0] request_track
    input  wire logic                              s_tlast,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    // [11:0] from_track, [23:12] to_track, [35:24] seek_distance,
    // [48:36] total_movement
    input  wire logic [lds_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic                              m_tlast,
    output int                                     o_fail_count,
    output int                                     o_pending,
    output int                                     o_sweeps,
    output int                                     o_seeks
);

    import lds_pkg::*;

    // one seek as it leaves the block
    typedef struct packed {
        logic [TRACK_W-1:0] from_track;
        logic [TRACK_W-1:0] to_track;
        logic [TRACK_W-1:0] distance;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_seek;

    // shadow of the block state
    logic [TRACK_W-1:0] shelf [MAX_REQUESTS];
    int                 stored;
    logic [TRACK_W-1:0] head_cfg;
    logic               sweep_down;

    t_seek seeks_due [$];
    int    fails;
    int    sweeps;
    int    seeks;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_sweeps     = 0;
        o_seeks      = 0;
    end

    // build the LOOK sequence for the stored tracks
    task automatic plan_sweep();
        int                 split;
        int                 k;
        int                 route [$];
        logic [TRACK_W-1:0] head;
        logic [TOTAL_W-1:0] total;
        t_seek              s;
        split = 0;
        while (split < stored && shelf[split] < head_cfg) split++;
        if (sweep_down) begin
            for (k = split - 1; k >= 0; k--) route.push_back(k);
            for (k = split; k < stored; k++) route.push_back(k);
        end else begin
            for (k = split; k < stored; k++) route.push_back(k);
            for (k = split - 1; k >= 0; k--) route.push_back(k);
        end
        head  = head_cfg;
        total = '0;
        for (k = 0; k < route.size(); k++) begin
            s.from_track = head;
            s.to_track   = shelf[route[k]];
            s.distance   = (s.to_track >= head) ? s.to_track - head : head - s.to_track;
            s.total      = total + {1'b0, s.distance};
            s.last       = (k == route.size() - 1);
            seeks_due.push_back(s);
            head  = s.to_track;
            total = s.total;
        end
    endtask

    // sorted insert; a full store drops the track but still honors the last mark
    task automatic file_request(input logic [TRACK_W-1:0] track, input logic last);
        int pos;
        if (stored < MAX_REQUESTS) begin
            pos = stored;
            while (pos > 0 && shelf[pos-1] > track) begin
                shelf[pos] = shelf[pos-1];
                pos--;
            end
            shelf[pos] = track;
            stored++;
        end
        if (last) begin
            plan_sweep();
            stored = 0;
            sweeps++;
        end
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: seek %0d %s mismatch, expected %0d, got %0d",
                     $time, seeks, field, want, got);
            fails++;
        end
    endtask

    task automatic check_seek(input t_seek got);
        t_seek want;
        if (seeks_due.size() == 0) begin
            $display("%0t ns: unexpected seek, expected none, got from %0d to %0d",
                     $time, got.from_track, got.to_track);
            fails++;
        end else begin
            want = seeks_due.pop_front();
            compare_field("from_track", want.from_track, got.from_track);
            compare_field("to_track", want.to_track, got.to_track);
            compare_field("seek_distance", want.distance, got.distance);
            compare_field("total_movement", want.total, got.total);
            compare_field("last_seek", want.last, got.last);
        end
        seeks++;
    endtask

    // sample every transaction at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stored     = 0;
            head_cfg   = '0;
            sweep_down = 1'b0;
            fails      = 0;
            sweeps     = 0;
            seeks      = 0;
            seeks_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_START_POS: head_cfg   = i_cfg_wdata[TRACK_W-1:0];
                    CFG_DIR_LEFT:  sweep_down = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                check_seek({m_tdata[TRACK_W-1:0],
                            m_tdata[2*TRACK_W-1:TRACK_W],
                            m_tdata[3*TRACK_W-1:2*TRACK_W],
                            m_tdata[3*TRACK_W+TOTAL_W-1:3*TRACK_W],
                            m_tlast});
            end
            if (s_tvalid && s_tready) file_request(s_tdata[TRACK_W-1:0], s_tlast);
        end
        o_fail_count <= fails;
        o_pending    <= seeks_due.size();
        o_sweeps     <= sweeps;
        o_seeks      <= seeks;
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the LOOK disk scheduler: a directed set of batches covering
// track extremes, heads at both ends, both sweep directions, requests on
// the head and duplicates, then random batches of mixed size and track
// spread, including overflowing ones, with random stalls on both streams.
// Checking is done by lds_seek_checker; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_top;

    import lds_pkg::*;

    localparam int DEPTH     = 32;
    localparam int ITEMS     = 420;
    localparam int IDLE_GAP  = 2 * DEPTH + 20;
    localparam int STALL_MAX = 4000;

    typedef enum {SPREAD, NEAR_HEAD, EDGES, REPEATS} t_track_mix;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr  = '0;
    logic [CFG_DW-1:0]    i_cfg_wdata = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // [11:0] request_track
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    // [11:0] from_track, [23:12] to_track, [35:24] seek_distance,
    // [48:36] total_movement
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int fail_count;
    int pending;
    int sweeps;
    int seeks;

    logic               calm   = 1'b0;
    logic               gappy  = 1'b0;
    logic [TRACK_W-1:0] head_now = '0;
    int                 sent      = 0;
    int                 overflows = 0;
    int                 quiet_cycles = 0;

    look_disk_scheduler #(
        .MAX_REQUESTS(DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    lds_seek_checker #(
        .MAX_REQUESTS(DEPTH)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_sweeps     (sweeps),
        .o_seeks      (seeks)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_MAX) begin
                $display("watchdog: no transaction for %0d cycles", STALL_MAX);
                $display("[look_disk_scheduler] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // seek sink: stall bursts mixed with long ready stretches
    initial begin : sink_pacing
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 60)) @(posedge i_clk);
            end
        end
    end

    // both registers, direction with junk in the unused bits
    task automatic program_head(input logic [TRACK_W-1:0] pos, input logic left);
        logic [CFG_DW-1:0] dir_word;
        dir_word    = CFG_DW'($urandom);
        dir_word[0] = left;
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_START_POS;
        i_cfg_wdata <= pos;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_DIR_LEFT;
        i_cfg_wdata <= dir_word;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        head_now = pos;
    endtask

    // one request transaction, optional gap in front
    task automatic push_request(input logic [TRACK_W-1:0] track, input logic last);
        if (gappy && !calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-TRACK_W){1'b0}}, track};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    // hold off until every seek is out and the block is idle
    task automatic drain_and_rest();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    function automatic logic [TRACK_W-1:0] pick_track(input t_track_mix mix);
        int t;
        case (mix)
            SPREAD:    t = $urandom_range(0, 4095);
            NEAR_HEAD: t = int'(head_now) + int'($urandom_range(0, 40)) - 20;
            EDGES: begin
                case ($urandom_range(0, 2))
                    0:       t = 0;
                    1:       t = 4095;
                    default: t = int'(head_now);
                endcase
            end
            default:   t = $urandom_range(0, 7) * 585;
        endcase
        if (t < 0) t = 0;
        if (t > 4095) t = 4095;
        return t[TRACK_W-1:0];
    endfunction

    task automatic send_batch(input int n, input t_track_mix mix);
        int i;
        for (i = 0; i < n; i++) push_request(pick_track(mix), i == n - 1);
    endtask

    initial begin : stimulus
        int         n;
        int         r;
        t_track_mix mix;
        logic [TRACK_W-1:0] pos;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, head at 0 sweeping up: extremes and a duplicate
        push_request(12'd4095, 1'b0);
        push_request(12'd0, 1'b0);
        push_request(12'd0, 1'b0);
        push_request(12'd2048, 1'b1);
        drain_and_rest();
        // head at the top sweeping down, one request right on the head
        program_head(12'd4095, 1'b1);
        push_request(12'd100, 1'b0);
        push_request(12'd4095, 1'b0);
        push_request(12'd5, 1'b1);
        drain_and_rest();
        // requests on both sides of the head and on it, sweeping up
        gappy = 1'b1;
        program_head(12'd2000, 1'b0);
        push_request(12'd1999, 1'b0);
        push_request(12'd2000, 1'b0);
        push_request(12'd2001, 1'b0);
        push_request(12'd10, 1'b0);
        push_request(12'd3000, 1'b1);
        drain_and_rest();
        // sweeping down with nothing below the head
        program_head(12'd2000, 1'b1);
        push_request(12'd3000, 1'b0);
        push_request(12'd2500, 1'b1);
        drain_and_rest();
        // sweeping up with nothing at or above the head
        program_head(12'd4095, 1'b0);
        push_request(12'd6, 1'b0);
        push_request(12'd5, 1'b1);
        drain_and_rest();
        // biggest total: up to the top, then back to the bottom
        program_head(12'd1, 1'b0);
        push_request(12'd4095, 1'b0);
        push_request(12'd0, 1'b1);
        drain_and_rest();
        // single request batch
        program_head(12'd777, 1'b1);
        push_request(12'd777, 1'b1);
        drain_and_rest();

        // random batches
        while (sent < ITEMS) begin
            if (ITEMS - sent < 60) calm <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                drain_and_rest();
                r = $urandom_range(0, 5);
                pos = (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 : TRACK_W'($urandom);
                program_head(pos, 1'($urandom_range(0, 1)));
            end
            r = $urandom_range(0, 19);
            if (r == 0) begin
                n = $urandom_range(DEPTH + 1, DEPTH + 8);
                overflows++;
            end else if (r < 3) begin
                n = $urandom_range(20, DEPTH);
            end else begin
                n = $urandom_range(1, 10);
            end
            r   = $urandom_range(0, 9);
            mix = (r < 5) ? SPREAD : (r < 7) ? NEAR_HEAD : (r < 9) ? EDGES : REPEATS;
            gappy = ($urandom_range(0, 2) != 0);
            send_batch(n, mix);
            if ($urandom_range(0, 3) == 0) drain_and_rest();
        end

        drain_and_rest();
        $display("covered %0d requests in %0d sweeps with %0d seeks checked,", sent, sweeps,
                 seeks);
        $display("heads at both ends, both directions, %0d overflowing batches", overflows);
        if (fail_count == 0 && pending == 0) begin
            $display("[look_disk_scheduler] OK");
        end else begin
            $display("[look_disk_scheduler] ERROR");
        end
        $finish;
    end

endmodule
